### rtl/sktab_pkg.sv
// Shared types and constants for the sorted key table; depends on nothing.
// Used by sktab_cell, sktab_gather, sorted_key_table and the testbench.
`default_nettype none

package sktab_pkg;

  localparam int DEPTH      = 64;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp_en;  // capture the compare flags against the command key
    logic ins_en;  // open a gap and place the new record
    logic del_en;  // close the gap left by the matching record
  } sktab_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_COMPARE = 4'b0010,
    S_APPLY   = 4'b0100,
    S_REPORT  = 4'b1000
  } sktab_state_t;

endpackage

`default_nettype wire

### rtl/sktab_cell.sv
// One slot of the sorted record chain: a key, two data words and compare flags.
// Depends on sktab_pkg.
`default_nettype none

module sktab_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire sktab_pkg::sktab_ctrl_t           ctrl,
  input  wire logic signed [sktab_pkg::KEY_W-1:0]  cmd_key,
  input  wire logic        [sktab_pkg::DATA_W-1:0] cmd_name,
  input  wire logic        [sktab_pkg::DATA_W-1:0] cmd_addr,
  input  wire logic                             occupied,
  input  wire logic                             prev_lt,
  input  wire logic signed [sktab_pkg::KEY_W-1:0]  prev_key,
  input  wire logic        [sktab_pkg::DATA_W-1:0] prev_name,
  input  wire logic        [sktab_pkg::DATA_W-1:0] prev_addr,
  input  wire logic signed [sktab_pkg::KEY_W-1:0]  next_key,
  input  wire logic        [sktab_pkg::DATA_W-1:0] next_name,
  input  wire logic        [sktab_pkg::DATA_W-1:0] next_addr,
  output logic signed      [sktab_pkg::KEY_W-1:0]  key,
  output logic             [sktab_pkg::DATA_W-1:0] name,
  output logic             [sktab_pkg::DATA_W-1:0] addr,
  output logic                                  lt,
  output logic                                  eq,
  output logic             [sktab_pkg::DATA_W-1:0] hit_name,
  output logic             [sktab_pkg::DATA_W-1:0] hit_addr
);
  import sktab_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp_en) begin
      lt <= occupied && (key < cmd_key);
      eq <= occupied && (key == cmd_key);
    end
  end

  // On an insert, slots below the insertion point keep their record; the first
  // slot at or above it takes the new record, each later slot its neighbour's.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !lt) begin
      if (prev_lt) begin
        key  <= cmd_key;
        name <= cmd_name;
        addr <= cmd_addr;
      end else begin
        key  <= prev_key;
        name <= prev_name;
        addr <= prev_addr;
      end
    end else if (ctrl.del_en && !lt) begin
      key  <= next_key;
      name <= next_name;
      addr <= next_addr;
    end
  end

  assign hit_name = eq ? name : '0;
  assign hit_addr = eq ? addr : '0;

endmodule

`default_nettype wire

### rtl/sktab_gather.sv
// Registered OR tree that collects the data words of the matching cell.
// Depends on sktab_pkg.
`default_nettype none

module sktab_gather (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic                          keep,
  input  wire logic [sktab_pkg::DATA_W-1:0]  hit_name [sktab_pkg::DEPTH],
  input  wire logic [sktab_pkg::DATA_W-1:0]  hit_addr [sktab_pkg::DEPTH],
  output logic      [sktab_pkg::DATA_W-1:0]  found_name,
  output logic      [sktab_pkg::DATA_W-1:0]  found_address
);
  import sktab_pkg::*;

  logic [DATA_W-1:0] leaf_name [NUM_GROUPS][GROUP];
  logic [DATA_W-1:0] leaf_addr [NUM_GROUPS][GROUP];
  logic [DATA_W-1:0] grp_name_next [NUM_GROUPS];
  logic [DATA_W-1:0] grp_addr_next [NUM_GROUPS];
  logic [DATA_W-1:0] grp_name [NUM_GROUPS];
  logic [DATA_W-1:0] grp_addr [NUM_GROUPS];

  for (genvar gi = 0; gi < NUM_GROUPS; gi++) begin : g_grp
    for (genvar gj = 0; gj < GROUP; gj++) begin : g_leaf
      localparam int IDX = gi * GROUP + gj;
      if (IDX < DEPTH) begin : g_real
        assign leaf_name[gi][gj] = hit_name[IDX];
        assign leaf_addr[gi][gj] = hit_addr[IDX];
      end else begin : g_pad
        assign leaf_name[gi][gj] = '0;
        assign leaf_addr[gi][gj] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_name_next[g] = '0;
      grp_addr_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_name_next[g] = grp_name_next[g] | leaf_name[g][j];
        grp_addr_next[g] = grp_addr_next[g] | leaf_addr[g][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_name[g] <= keep ? grp_name_next[g] : '0;
        grp_addr[g] <= keep ? grp_addr_next[g] : '0;
      end
    end
  end

  always_comb begin
    found_name    = '0;
    found_address = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      found_name    = found_name | grp_name[g];
      found_address = found_address | grp_addr[g];
    end
  end

endmodule

`default_nettype wire

### rtl/sorted_key_table.sv
// Sorted key table: a chain of DEPTH cells held in ascending signed key order.
// A transaction passes through the compare, apply and report states; the result
// strobe done is high in the report state, and a new transaction may be accepted
// in the report cycle. The receiver cannot stall.
// Reset (rst, synchronous) empties the table and returns the sequencer to idle.
// Depends on sktab_pkg, sktab_cell and sktab_gather.
`default_nettype none

module sorted_key_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [sktab_pkg::OP_W-1:0]    op,
  input  wire logic signed [sktab_pkg::KEY_W-1:0]   key,
  input  wire logic        [sktab_pkg::DATA_W-1:0]  name_word,
  input  wire logic        [sktab_pkg::DATA_W-1:0]  address_word,
  output logic                                   done,
  output logic             [sktab_pkg::STATUS_W-1:0] status,
  output logic             [sktab_pkg::DATA_W-1:0]  found_name,
  output logic             [sktab_pkg::DATA_W-1:0]  found_address
);
  import sktab_pkg::*;

  // Sequencer. In the compare cycle every cell checks its key against the
  // command key at once; in the apply cycle the chain shifts by one place for
  // a successful insert or delete and the gather tree latches the matching
  // data; in the report cycle the result is shown for exactly one cycle.
  sktab_state_t state;
  sktab_state_t state_next;

  logic                     accept;
  logic [OP_W-1:0]          cmd_op;
  logic signed [KEY_W-1:0]  cmd_key;
  logic [DATA_W-1:0]        cmd_name;
  logic [DATA_W-1:0]        cmd_addr;
  logic [CNT_W-1:0]         count;
  logic [STATUS_W-1:0]      status_next;

  logic                     hit;
  logic                     full;
  sktab_ctrl_t              ctrl;

  logic [DEPTH-1:0]         occ_vec;
  logic [DEPTH-1:0]         lt_vec;
  logic [DEPTH-1:0]         eq_vec;
  logic signed [KEY_W-1:0]  cell_key  [DEPTH];
  logic [DATA_W-1:0]        cell_name [DEPTH];
  logic [DATA_W-1:0]        cell_addr [DEPTH];
  logic [DATA_W-1:0]        hit_name  [DEPTH];
  logic [DATA_W-1:0]        hit_addr  [DEPTH];

  assign busy   = (state == S_COMPARE) || (state == S_APPLY);
  assign accept = start && !busy;
  assign done   = (state == S_REPORT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_COMPARE;
      S_COMPARE: state_next = S_APPLY;
      S_APPLY:   state_next = S_REPORT;
      S_REPORT:  state_next = start ? S_COMPARE : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The command is held for the whole transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op   <= op;
      cmd_key  <= key;
      cmd_name <= name_word;
      cmd_addr <= address_word;
    end
  end

  // The match flags are one-hot at most because keys in the table are unique.
  assign hit  = |eq_vec;
  assign full = (count == CNT_W'(DEPTH));

  always_comb begin
    status_next = ST_MISSING;
    unique case (cmd_op)
      OP_INSERT: begin
        if (hit) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
        end
      end
      OP_FIND, OP_DELETE: status_next = hit ? ST_OK : ST_MISSING;
      default:            status_next = ST_MISSING;
    endcase
  end

  assign ctrl.cmp_en = (state == S_COMPARE);
  assign ctrl.ins_en = (state == S_APPLY) && (cmd_op == OP_INSERT) && !hit && !full;
  assign ctrl.del_en = (state == S_APPLY) && (cmd_op == OP_DELETE) && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins_en) begin
      count <= count + 1'b1;
    end else if (ctrl.del_en) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      status <= status_next;
    end
  end

  // Slots at or above the record count hold no record and never match.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                     p_lt;
    logic signed [KEY_W-1:0]  p_key;
    logic [DATA_W-1:0]        p_name;
    logic [DATA_W-1:0]        p_addr;
    logic signed [KEY_W-1:0]  n_key;
    logic [DATA_W-1:0]        n_name;
    logic [DATA_W-1:0]        n_addr;

    assign occ_vec[i] = (count > IDX);

    if (i == 0) begin : g_head
      assign p_lt   = 1'b1;
      assign p_key  = '0;
      assign p_name = '0;
      assign p_addr = '0;
    end else begin : g_body
      assign p_lt   = lt_vec[i-1];
      assign p_key  = cell_key[i-1];
      assign p_name = cell_name[i-1];
      assign p_addr = cell_addr[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_key  = '0;
      assign n_name = '0;
      assign n_addr = '0;
    end else begin : g_link
      assign n_key  = cell_key[i+1];
      assign n_name = cell_name[i+1];
      assign n_addr = cell_addr[i+1];
    end

    sktab_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cmd_key   (cmd_key),
      .cmd_name  (cmd_name),
      .cmd_addr  (cmd_addr),
      .occupied  (occ_vec[i]),
      .prev_lt   (p_lt),
      .prev_key  (p_key),
      .prev_name (p_name),
      .prev_addr (p_addr),
      .next_key  (n_key),
      .next_name (n_name),
      .next_addr (n_addr),
      .key       (cell_key[i]),
      .name      (cell_name[i]),
      .addr      (cell_addr[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .hit_name  (hit_name[i]),
      .hit_addr  (hit_addr[i])
    );
  end

  // Only a find returns data; every other transaction reports zero words.
  sktab_gather u_gather (
    .clk           (clk),
    .load          (state == S_APPLY),
    .keep          (cmd_op == OP_FIND),
    .hit_name      (hit_name),
    .hit_addr      (hit_addr),
    .found_name    (found_name),
    .found_address (found_address)
  );

  // A result strobe always follows an apply cycle.
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("result strobe without a preceding apply cycle");

  // The record count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("record count beyond table depth");

  // Sorted unique keys allow at most one matching cell.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  // A successful insert grows the table by exactly one record.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && cmd_op == OP_INSERT && status == ST_OK)
      |-> count == CNT_W'($past(count) + 1'b1))
    else $error("successful insert did not add one record");

  // Every apply cycle directly follows a compare cycle, so the match flags are fresh.
  a_apply_after_compare: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $past(state == S_COMPARE))
    else $error("apply cycle without a compare cycle");

endmodule

`default_nettype wire

### dv/sorted_key_table_test.sv
// Self-checking testbench for sorted_key_table: directed and random transactions
// checked against a behavioural copy of the table kept in the testbench.
// Depends on sktab_pkg and the sorted_key_table RTL.
`default_nettype none

module sorted_key_table_test;
  import sktab_pkg::*;

  // The opcode space has one code that the block must treat as a miss.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1750;
  // Cycles with no transaction on either side before the run is abandoned. The
  // longest legal quiet stretch is a long sender gap plus one transaction's latency.
  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_MAX = 96;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [KEY_W-1:0]  key;
    logic [DATA_W-1:0]        name_word;
    logic [DATA_W-1:0]        address_word;
    int unsigned              gap;    // idle cycles before the command is presented
    bit                       drain;  // hold back until every reply has arrived
  } command_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] name;
    logic [DATA_W-1:0] address;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [OP_W-1:0]         op = OP_FIND;
  logic signed [KEY_W-1:0] key = '0;
  logic [DATA_W-1:0]       name_word = '0;
  logic [DATA_W-1:0]       address_word = '0;
  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [DATA_W-1:0]       found_name;
  logic [DATA_W-1:0]       found_address;

  sorted_key_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key          (key),
    .name_word    (name_word),
    .address_word (address_word),
    .done         (done),
    .status       (status),
    .found_name   (found_name),
    .found_address(found_address)
  );

  always #6 clk = ~clk;

  // Commands waiting to be driven, and replies that have been predicted but not
  // yet seen on the result ports.
  command_t pending[$];
  reply_t   awaited[$];

  int  mismatches = 0;
  int  quiet = 0;
  int  issued = 0;
  logic took = 1'b0;

  // Shadow copy of the table. Slots at or above shadow_count are never read.
  logic signed [KEY_W-1:0] shadow_key[DEPTH];
  logic [DATA_W-1:0]       shadow_name[DEPTH];
  logic [DATA_W-1:0]       shadow_address[DEPTH];
  int                      shadow_count = 0;

  // Key pool for the random part. It persists across episodes so that the table
  // can be filled by one episode and emptied by the next.
  logic signed [KEY_W-1:0] key_pool[POOL_MAX];
  int                      pool_size = 80;

  // Applies one accepted transaction to the shadow table and returns the reply
  // that the block must give for it.
  function automatic reply_t table_step(logic [OP_W-1:0] c_op, logic signed [KEY_W-1:0] c_key,
                                        logic [DATA_W-1:0] c_name, logic [DATA_W-1:0] c_addr);
    reply_t r;
    int     slot;
    int     i;
    bit     hit;
    r.status  = ST_MISSING;
    r.name    = '0;
    r.address = '0;
    // The first slot whose key is not below the command key; signed order.
    slot = 0;
    while (slot < shadow_count && shadow_key[slot] < c_key) slot++;
    hit = (slot < shadow_count) && (shadow_key[slot] == c_key);
    case (c_op)
      OP_INSERT: begin
        if (hit) begin
          // A present key is reported as a duplicate even on a full table.
          r.status = ST_DUP;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > slot; i--) begin
            shadow_key[i]     = shadow_key[i-1];
            shadow_name[i]    = shadow_name[i-1];
            shadow_address[i] = shadow_address[i-1];
          end
          shadow_key[slot]     = c_key;
          shadow_name[slot]    = c_name;
          shadow_address[slot] = c_addr;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      OP_FIND: begin
        if (hit) begin
          r.status  = ST_OK;
          r.name    = shadow_name[slot];
          r.address = shadow_address[slot];
        end
      end
      OP_DELETE: begin
        if (hit) begin
          for (i = slot; i + 1 < shadow_count; i++) begin
            shadow_key[i]     = shadow_key[i+1];
            shadow_name[i]    = shadow_name[i+1];
            shadow_address[i] = shadow_address[i+1];
          end
          shadow_count--;
          r.status = ST_OK;
        end
      end
      default: ;  // the unused opcode is a miss with zero data words
    endcase
    return r;
  endfunction

  // Most gaps are short, some a few cycles and a handful long; no_gaps makes all zero.
  function automatic int unsigned pick_gap(bit no_gaps);
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_command(logic [OP_W-1:0] c_op, logic signed [KEY_W-1:0] c_key,
                               logic [DATA_W-1:0] c_name, logic [DATA_W-1:0] c_addr,
                               int unsigned c_gap, bit c_drain);
    command_t c;
    c.op           = c_op;
    c.key          = c_key;
    c.name_word    = c_name;
    c.address_word = c_addr;
    c.gap          = c_gap;
    c.drain        = c_drain;
    pending.push_back(c);
    issued++;
  endtask

  // Short directed opening: field extremes, every opcode, misses on an empty
  // table, duplicates, the gap closing after a delete, and data words being
  // ignored by find and delete.
  task automatic directed_opening();
    logic signed [KEY_W-1:0] kmin;
    logic signed [KEY_W-1:0] kmax;
    kmin = {1'b1, {(KEY_W-1){1'b0}}};
    kmax = {1'b0, {(KEY_W-1){1'b1}}};
    queue_command(OP_FIND,   '0,    '1, '1, 0, 1'b0);
    queue_command(OP_DELETE, kmin,  '1, '1, 0, 1'b0);
    queue_command(OP_UNUSED, kmax,  $urandom, $urandom, 1, 1'b0);
    queue_command(OP_INSERT, '0,    '0, '0, 0, 1'b0);
    queue_command(OP_INSERT, kmin,  '1, '1, 0, 1'b0);
    queue_command(OP_INSERT, kmax,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 1'b0);
    queue_command(OP_INSERT, -1,    $urandom, $urandom, 2, 1'b0);
    queue_command(OP_INSERT, 1,     $urandom, $urandom, 0, 1'b0);
    queue_command(OP_INSERT, kmax,  '0, '1, 0, 1'b0);
    queue_command(OP_FIND,   kmin,  32'h1234_5678, 32'h9ABC_DEF0, 0, 1'b0);
    queue_command(OP_FIND,   kmax,  '1, '0, 0, 1'b0);
    queue_command(OP_FIND,   '0,    $urandom, $urandom, 0, 1'b0);
    queue_command(OP_FIND,   2,     '0, '0, 0, 1'b0);
    queue_command(OP_FIND,   -2,    '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, '0,    '1, '1, 0, 1'b0);
    queue_command(OP_FIND,   '0,    '0, '0, 0, 1'b0);
    queue_command(OP_FIND,   1,     '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, '0,    '0, '0, 0, 1'b0);
    queue_command(OP_UNUSED, kmax,  '1, '1, 0, 1'b0);
    queue_command(OP_FIND,   kmax,  '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, kmin,  '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, kmax,  '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, -1,    '0, '0, 0, 1'b0);
    queue_command(OP_DELETE, 1,     '0, '0, 0, 1'b0);
    queue_command(OP_FIND,   1,     '0, '0, 0, 1'b0);
  endtask

  // Fills the table past its depth with distinct keys, so that the later
  // inserts are refused as full, then checks a duplicate and a find on the full
  // table and empties it again in a shuffled order.
  task automatic fill_and_empty();
    logic signed [KEY_W-1:0] base;
    logic signed [KEY_W-1:0] fill_key[DEPTH + 6];
    int unsigned             stride;
    int                      i;
    int                      j;
    logic signed [KEY_W-1:0] swap;
    base   = $urandom;
    stride = $urandom_range(1, 50000) | 1;
    for (i = 0; i < DEPTH + 6; i++) fill_key[i] = base + i * stride;
    for (i = DEPTH + 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = fill_key[i]; fill_key[i] = fill_key[j]; fill_key[j] = swap;
    end
    for (i = 0; i < DEPTH + 6; i++)
      queue_command(OP_INSERT, fill_key[i], $urandom, $urandom, pick_gap(i < 32), i == 0);
    queue_command(OP_INSERT, fill_key[0], $urandom, $urandom, 0, 1'b0);
    queue_command(OP_FIND, fill_key[3], $urandom, $urandom, 0, 1'b0);
    for (i = DEPTH + 5; i >= 0; i--)
      queue_command(OP_DELETE, fill_key[i], $urandom, $urandom, pick_gap(1'b0), 1'b0);
  endtask

  // One random episode. Grow episodes favour inserts, shrink episodes favour
  // deletes; keys come mostly from the shared pool so that hits, duplicates and
  // full refusals are frequent, with some noise keys and the unused opcode.
  task automatic random_episode(bit drain_first);
    int unsigned             length;
    int unsigned             mode;
    int unsigned             roll;
    int unsigned             n;
    bit                      no_gaps;
    logic [OP_W-1:0]         c_op;
    logic signed [KEY_W-1:0] c_key;
    int                      i;
    if ($urandom_range(0, 3) == 0) begin
      pool_size = $urandom_range(70, POOL_MAX);
      for (i = 0; i < 20; i++) key_pool[$urandom_range(0, POOL_MAX - 1)] = $urandom;
    end
    length  = $urandom_range(60, 220);
    mode    = $urandom_range(0, 2);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (n = 0; n < length; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        c_op = OP_UNUSED;
      end else begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       c_op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_FIND : OP_DELETE;
          1:       c_op = (roll < 20) ? OP_INSERT : (roll < 40) ? OP_FIND : OP_DELETE;
          default: c_op = (roll < 40) ? OP_INSERT : (roll < 75) ? OP_FIND : OP_DELETE;
        endcase
      end
      if ($urandom_range(0, 99) < 8) c_key = $urandom;
      else c_key = key_pool[$urandom_range(0, pool_size - 1)];
      queue_command(c_op, c_key, $urandom, $urandom, pick_gap(no_gaps), drain_first && n == 0);
    end
  endtask

  // Driver. Inputs change on the falling edge. The transaction presented last is
  // known to be taken when the monitor saw start high with busy low; start is
  // then either kept high for the next command or dropped, with one assignment.
  always @(negedge clk) begin : drive
    logic        next_start;
    command_t    c;
    int unsigned gap_left;
    bit          gap_armed;
    next_start = start;
    if (!rst) begin
      if (start && took) next_start = 1'b0;
      if (!next_start && pending.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = pending[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].drain || awaited.size() == 0) begin
          c = pending.pop_front();
          gap_armed    = 1'b0;
          next_start   = 1'b1;
          op           <= c.op;
          key          <= c.key;
          name_word    <= c.name_word;
          address_word <= c.address_word;
        end
      end
    end
    start <= next_start;
  end

  // Monitor, predictor and watchdog, all on the rising edge. A reply is checked
  // before a transaction accepted on the same edge is predicted, since the reply
  // belongs to an older transaction.
  always @(posedge clk) begin : observe
    reply_t want;
    bit     accept;
    if (rst) begin
      took <= 1'b0;
    end else begin
      accept = start && !busy;
      took <= accept;
      if (done) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $error("reply with no transaction outstanding, status %0d", status);
        end else begin
          want = awaited.pop_front();
          if (status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
          if (found_name !== want.name) begin
            mismatches++;
            $error("found_name: expected %h, got %h", want.name, found_name);
          end
          if (found_address !== want.address) begin
            mismatches++;
            $error("found_address: expected %h, got %h", want.address, found_address);
          end
        end
      end
      if (accept) awaited.push_back(table_step(op, key, name_word, address_word));
      if (accept || done) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : run
    int i;
    int episode;
    for (i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    key_pool[0] = {1'b1, {(KEY_W-1){1'b0}}};
    key_pool[1] = {1'b0, {(KEY_W-1){1'b1}}};
    key_pool[2] = '0;
    key_pool[3] = '1;
    directed_opening();
    fill_and_empty();
    // The first random episode, and some later ones, start only once the block
    // has drained completely.
    episode = 0;
    while (issued < ITEM_TARGET) begin
      random_episode(episode == 0 || $urandom_range(0, 2) == 0);
      episode++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || awaited.size() != 0) @(posedge clk);
    // A few extra cycles to catch a stray reply after the last expected one.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/sktab_pkg.sv
rtl/sktab_cell.sv
rtl/sktab_gather.sv
rtl/sorted_key_table.sv
dv/sorted_key_table_test.sv
